// ----- design/rscx_pkg.sv -----
package rscx_pkg;

  localparam int unsigned INSTR_BYTES = 16;

  typedef enum logic [4:0] {
    OP_INP  = 5'd0,
    OP_OUT  = 5'd1,
    OP_MOV  = 5'd2,
    OP_ADD  = 5'd3,
    OP_SUB  = 5'd4,
    OP_MUL  = 5'd5,
    OP_DIV  = 5'd6,
    OP_SQR  = 5'd7,
    OP_BNE  = 5'd8,
    OP_BEQ  = 5'd9,
    OP_BGT  = 5'd10,
    OP_BLT  = 5'd11,
    OP_BGE  = 5'd12,
    OP_BLE  = 5'd13,
    OP_JUMP = 5'd14,
    OP_PUSH = 5'd15,
    OP_POP  = 5'd16,
    OP_CALL = 5'd17,
    OP_RET  = 5'd18,
    OP_HALT = 5'd19
  } opcode_e;

  typedef enum logic [2:0] {
    F_NONE  = 3'd0,
    F_REG   = 3'd1,
    F_RANGE = 3'd2,
    F_DIV0  = 3'd3,
    F_IMM   = 3'd4,
    F_UNDER = 3'd5,
    F_CALL  = 3'd6
  } fault_e;

  function automatic logic [1:0] arg_count(input logic [4:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op) inside
      OP_INP, OP_OUT, OP_JUMP, OP_PUSH, OP_POP, OP_CALL, OP_RET: n = 2'd1;
      OP_MOV, OP_SQR:                                        n = 2'd2;
      [OP_ADD:OP_DIV], [OP_BNE:OP_BLE]:                      n = 2'd3;
      default:                                               n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- design/rscx_ram.sv -----
module rscx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- design/rscx_divsqrt.sv -----
module rscx_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sqrt_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] result_o
);
  localparam logic [5:0] DivSteps  = 6'd32;
  localparam logic [5:0] SqrtSteps = 6'd16;

  logic        busy_q, busy_d, done_d, sqrt_q, sqrt_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d, bit_q, bit_d, div_q, div_d;
  logic [32:0] rem_sh, diff;
  logic [31:0] trial;

  assign result_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    bit_d  = bit_q;
    div_d  = div_q;
    rem_sh = {rem_q[31:0], quo_q[31]};
    diff   = rem_sh - {1'b0, div_q};
    trial  = quo_q + bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      sqrt_d = sqrt_i;
      cnt_d  = sqrt_i ? SqrtSteps : DivSteps;
      div_d  = b_i;
      bit_d  = 32'h4000_0000;
      if (sqrt_i) begin
        rem_d = {1'b0, a_i};
        quo_d = 32'd0;
      end else begin
        rem_d = 33'd0;
        quo_d = a_i;
      end
    end else if (busy_q) begin
      if (sqrt_q) begin
        if (rem_q[31:0] >= trial) begin
          rem_d = {1'b0, rem_q[31:0] - trial};
          quo_d = (quo_q >> 1) + bit_q;
        end else begin
          quo_d = quo_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else if (!diff[32]) begin
        rem_d = diff;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_o <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    bit_q  <= bit_d;
    div_q  <= div_d;
  end
endmodule

// ----- design/register_stack_cpu_execute.sv -----
// channel | handshake                | payload
// request | req_valid_i / req_ready_o | req_type_i operand_modes_i *_operand_i input_word_i
// result  | res_valid_o / res_ready_i | next_pc_o out_word_o out_valid_o halted_o fault_code_o
// one item at a time; each stack word is read or written a byte at a time, and
// div and sqrt run in the shared div/sqrt unit
// reset clears registers, pc, stack and call depths and the halt flag
// a new item is taken while a result waits; completion stalls until it leaves
module register_stack_cpu_execute #(
  parameter int unsigned NUM_REGS    = 8,
  parameter int unsigned STACK_BYTES = 1024,
  parameter int unsigned CALL_DEPTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [4:0]  req_type_i,
  input  logic [5:0]  operand_modes_i,
  input  logic [31:0] first_operand_i,
  input  logic [31:0] second_operand_i,
  input  logic [31:0] third_operand_i,
  input  logic [31:0] input_word_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [31:0] next_pc_o,
  output logic [31:0] out_word_o,
  output logic        out_valid_o,
  output logic        halted_o,
  output logic [2:0]  fault_code_o
);
  import rscx_pkg::*;

  localparam int unsigned RGW = $clog2(NUM_REGS);
  localparam int unsigned AW  = $clog2(STACK_BYTES);
  localparam int unsigned CW  = $clog2(STACK_BYTES + 1);
  localparam int unsigned RAW = $clog2(CALL_DEPTH);
  localparam int unsigned DW  = $clog2(CALL_DEPTH + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_FETCH  = 4'd2;
  localparam logic [3:0] S_MRD    = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_UNIT   = 4'd5;
  localparam logic [3:0] S_STORE  = 4'd6;
  localparam logic [3:0] S_MWR    = 4'd7;
  localparam logic [3:0] S_RET    = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [4:0]    op_q, op_d;
  logic [5:0]    modes_q, modes_d;
  logic [31:0]   w_q [3];
  logic [31:0]   w_d [3];
  logic [31:0]   inw_q, inw_d, a_q, a_d, b_q, b_d, res_q, res_d, tmp_q, tmp_d;
  logic [31:0]   npc_q, npc_d, ow_q, ow_d, pc_q, pc_d;
  logic          ov_q, ov_d, fsel_q, fsel_d, halt_q, halt_d;
  logic [2:0]    fault_q, fault_d, bc_q, bc_d;
  logic [AW-1:0] maddr_q, maddr_d;
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [31:0]   regs_q [NUM_REGS];
  logic          rf_we;
  logic [31:0]   rf_wdata;

  logic          res_valid_d, ov_out_d, halted_d;
  logic [31:0]   next_pc_d, out_word_d;
  logic [2:0]    fault_out_d;

  logic [1:0]    opsel;
  logic [31:0]   cur_w, reg_rd, cur_val, mem_word, end_c32;
  logic          cur_rf, cur_mf, rd_ok, wr_ok, bad_reg, is_br, two_fetch, take;
  logic [32:0]   cnt33, val33;
  logic [CW-1:0] end_c;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  logic          rs_we;
  logic [RAW-1:0] rs_addr;
  logic [31:0]   rs_wdata, rs_rdata;
  logic          unit_start, unit_done;
  logic [31:0]   unit_res;

  rscx_ram #(.WIDTH(8), .DEPTH(STACK_BYTES)) u_stack (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(res_q[7:0]),
    .rdata_o(mem_rdata)
  );

  rscx_ram #(.WIDTH(32), .DEPTH(CALL_DEPTH)) u_calls (
    .clk_i  (clk_i),
    .we_i   (rs_we),
    .addr_i (rs_addr),
    .wdata_i(rs_wdata),
    .rdata_o(rs_rdata)
  );

  rscx_divsqrt u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .sqrt_i  (op_q == OP_SQR),
    .a_i     (a_q),
    .b_i     (b_q),
    .done_o  (unit_done),
    .result_o(unit_res)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign is_br       = (op_q >= OP_BNE) && (op_q <= OP_BLE);
  assign two_fetch   = is_br || ((op_q >= OP_ADD) && (op_q <= OP_DIV));
  assign mem_addr    = maddr_q + AW'(bc_q);
  assign mem_we      = (state_q == S_MWR);
  assign cnt33       = 33'(count_q);
  assign mem_word    = {mem_rdata, tmp_q[31:8]};
  assign end_c32     = 32'(maddr_q) + 32'd4;
  assign end_c       = CW'(end_c32);

  always_comb begin
    if (state_q != S_FETCH) begin
      opsel = 2'd0;
    end else if (!fsel_q) begin
      opsel = (is_br || op_q == OP_OUT) ? 2'd0 : 2'd1;
    end else begin
      opsel = is_br ? 2'd1 : 2'd2;
    end
    cur_w   = w_q[opsel];
    cur_rf  = modes_q[{opsel, 1'b1}];
    cur_mf  = modes_q[{opsel, 1'b0}];
    reg_rd  = regs_q[cur_w[RGW-1:0]];
    cur_val = cur_rf ? reg_rd : cur_w;
    val33   = {1'b0, cur_val};
    rd_ok   = (cnt33 >= 33'd4) && (val33 + 33'd4 <= cnt33);
    wr_ok   = (val33 <= cnt33) && (val33 + 33'd4 <= 33'(STACK_BYTES));
    bad_reg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < arg_count(op_q)) && modes_q[2*i+1] && (w_q[i] >= 32'(NUM_REGS))) begin
        bad_reg = 1'b1;
      end
    end
    case (op_q)
      OP_BNE:  take = a_q != b_q;
      OP_BEQ:  take = a_q == b_q;
      OP_BGT:  take = a_q > b_q;
      OP_BLT:  take = a_q < b_q;
      OP_BGE:  take = a_q >= b_q;
      default: take = a_q <= b_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q; modes_d = modes_q; w_d = w_q; inw_d = inw_q;
    a_d = a_q; b_d = b_q; res_d = res_q; tmp_d = tmp_q;
    npc_d = npc_q; ow_d = ow_q; ov_d = ov_q; pc_d = pc_q;
    fsel_d = fsel_q; halt_d = halt_q; fault_d = fault_q; bc_d = bc_q;
    maddr_d = maddr_q; count_d = count_q; depth_d = depth_q;
    rf_we = 1'b0; rf_wdata = res_q;
    rs_we = 1'b0; rs_addr = depth_q[RAW-1:0]; rs_wdata = pc_q + 32'(INSTR_BYTES);
    unit_start = 1'b0;
    res_valid_d = res_valid_o && !res_ready_i;
    next_pc_d = next_pc_o; out_word_d = out_word_o; ov_out_d = out_valid_o;
    halted_d = halted_o; fault_out_d = fault_code_o;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d    = req_type_i;
          modes_d = operand_modes_i;
          w_d[0]  = first_operand_i;
          w_d[1]  = second_operand_i;
          w_d[2]  = third_operand_i;
          inw_d   = input_word_i;
          npc_d   = halt_q ? pc_q : pc_q + 32'(INSTR_BYTES);
          fault_d = F_NONE;
          ow_d    = 32'd0;
          ov_d    = 1'b0;
          fsel_d  = 1'b0;
          state_d = halt_q ? S_FIN : S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FIN;
        if (bad_reg) begin
          fault_d = F_REG;
        end else begin
          case (op_q)
            OP_INP: begin
              res_d   = inw_q;
              state_d = S_STORE;
            end
            OP_OUT, OP_MOV, OP_SQR, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
            OP_BNE, OP_BEQ, OP_BGT, OP_BLT, OP_BGE, OP_BLE: begin
              state_d = S_FETCH;
            end
            OP_JUMP: npc_d = w_q[0];
            OP_PUSH: begin
              if (w_q[0] >= 32'(NUM_REGS)) begin
                fault_d = F_REG;
              end else if (cnt33 + 33'd4 > 33'(STACK_BYTES)) begin
                fault_d = F_RANGE;
              end else begin
                res_d   = reg_rd;
                maddr_d = AW'(count_q);
                bc_d    = 3'd0;
                state_d = S_MWR;
              end
            end
            OP_POP: begin
              if (cnt33 < 33'd4) begin
                fault_d = F_UNDER;
              end else if (w_q[0] >= 32'(NUM_REGS)) begin
                fault_d = F_REG;
              end else begin
                maddr_d = AW'(count_q - CW'(4));
                bc_d    = 3'd0;
                state_d = S_MRD;
              end
            end
            OP_CALL: begin
              if (depth_q >= DW'(CALL_DEPTH)) begin
                fault_d = F_CALL;
              end else begin
                rs_we   = 1'b1;
                depth_d = depth_q + DW'(1);
                npc_d   = w_q[0];
              end
            end
            OP_RET: begin
              if (depth_q == '0) begin
                fault_d = F_CALL;
              end else begin
                rs_addr = RAW'(depth_q - DW'(1));
                depth_d = depth_q - DW'(1);
                state_d = S_RET;
              end
            end
            OP_HALT: begin
              halt_d = 1'b1;
              npc_d  = pc_q;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_FETCH, S_MRD: begin
        if (state_q == S_FETCH && cur_mf) begin
          if (rd_ok) begin
            maddr_d = cur_val[AW-1:0];
            bc_d    = 3'd0;
            state_d = S_MRD;
          end else begin
            fault_d = F_RANGE;
            state_d = S_FIN;
          end
        end else if (state_q == S_MRD && bc_q != 3'd4) begin
          bc_d = bc_q + 3'd1;
          if (bc_q != 3'd0) begin
            tmp_d = mem_word;
          end
        end else if (state_q == S_MRD && op_q == OP_POP) begin
          rf_we    = 1'b1;
          rf_wdata = mem_word;
          count_d  = count_q - CW'(4);
          state_d  = S_FIN;
        end else begin
          if (!fsel_q) begin
            a_d = (state_q == S_MRD) ? mem_word : cur_val;
          end else begin
            b_d = (state_q == S_MRD) ? mem_word : cur_val;
          end
          if (!fsel_q && two_fetch) begin
            fsel_d  = 1'b1;
            state_d = S_FETCH;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        state_d = S_STORE;
        case (op_q)
          OP_OUT: begin
            ow_d    = a_q;
            ov_d    = 1'b1;
            state_d = S_FIN;
          end
          OP_MOV: res_d = a_q;
          OP_ADD: res_d = a_q + b_q;
          OP_SUB: res_d = a_q - b_q;
          OP_MUL: res_d = a_q * b_q;
          OP_DIV: begin
            if (b_q == 32'd0) begin
              fault_d = F_DIV0;
              state_d = S_FIN;
            end else begin
              unit_start = 1'b1;
              state_d    = S_UNIT;
            end
          end
          OP_SQR: begin
            unit_start = 1'b1;
            state_d    = S_UNIT;
          end
          default: begin
            if (take) begin
              npc_d = w_q[2];
            end
            state_d = S_FIN;
          end
        endcase
      end
      S_UNIT: begin
        if (unit_done) begin
          res_d   = unit_res;
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        state_d = S_FIN;
        if (!cur_rf && !cur_mf) begin
          fault_d = F_IMM;
        end else if (!cur_mf) begin
          rf_we = 1'b1;
        end else if (wr_ok) begin
          maddr_d = cur_val[AW-1:0];
          bc_d    = 3'd0;
          state_d = S_MWR;
        end else begin
          fault_d = F_RANGE;
        end
      end
      S_MWR: begin
        res_d = res_q >> 8;
        bc_d  = bc_q + 3'd1;
        if (bc_q == 3'd3) begin
          if (end_c > count_q) begin
            count_d = end_c;
          end
          state_d = S_FIN;
        end
      end
      S_RET: begin
        npc_d   = rs_rdata;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!res_valid_o || res_ready_i) begin
          res_valid_d = 1'b1;
          if (fault_q != F_NONE) begin
            next_pc_d  = pc_q;
            out_word_d = 32'd0;
            ov_out_d   = 1'b0;
            halted_d   = 1'b1;
            halt_d     = 1'b1;
          end else begin
            next_pc_d  = npc_q;
            pc_d       = npc_q;
            out_word_d = ow_q;
            ov_out_d   = ov_q;
            halted_d   = halt_q;
          end
          fault_out_d = fault_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= '0;
      halt_q       <= 1'b0;
      count_q      <= '0;
      depth_q      <= '0;
      res_valid_o  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      count_q     <= count_d;
      depth_q     <= depth_d;
      res_valid_o <= res_valid_d;
      if (rf_we) begin
        regs_q[w_q[0][RGW-1:0]] <= rf_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    modes_q      <= modes_d;
    w_q          <= w_d;
    inw_q        <= inw_d;
    a_q          <= a_d;
    b_q          <= b_d;
    res_q        <= res_d;
    tmp_q        <= tmp_d;
    npc_q        <= npc_d;
    ow_q         <= ow_d;
    ov_q         <= ov_d;
    fsel_q       <= fsel_d;
    fault_q      <= fault_d;
    bc_q         <= bc_d;
    maddr_q      <= maddr_d;
    next_pc_o    <= next_pc_d;
    out_word_o   <= out_word_d;
    out_valid_o  <= ov_out_d;
    halted_o     <= halted_d;
    fault_code_o <= fault_out_d;
  end
endmodule
